// ----- rtl/sem_pkg.sv -----
// sem_pkg: shared widths, register indexes, queue item types and the size clamp
// for the Sobel edge magnitude block. Depends on nothing.
package sem_pkg;

	localparam int PIX_W     = 8;
	localparam int POS_W     = 10;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 4;
	localparam int WIN_N     = 9;
	localparam int MIN_SIZE  = 3;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd640;
	localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd480;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

	// front-to-back queue
	localparam int Q_DEPTH = 2;

	localparam logic [PIX_W-1:0] MAG_SAT = 8'd255;

	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             done;
	} sem_meta_t;

	// window after the shift: [0..2] top row, [3..5] middle, [6..8] bottom
	typedef struct packed {
		logic [WIN_N-1:0][PIX_W-1:0] win;
		sem_meta_t                   meta;
	} sem_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} sem_qstat_t;

	// frame size limited to MIN_SIZE..hi
	function automatic int clamp_size(input logic [CFG_W-1:0] v, input int hi);
		int r;
		r = int'(v);
		if (r < MIN_SIZE) begin
			r = MIN_SIZE;
		end else if (r > hi) begin
			r = hi;
		end
		return r;
	endfunction

endpackage

// ----- rtl/sem_if.sv -----
// sem_if: valid/ready channel interfaces for pixels, results and config writes.
// Depends on sem_pkg.
interface sem_pix_if;
	import sem_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             frame_start;
	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink (input valid, input pixel, input frame_start, output ready);
	modport monitor (input valid, input ready, input pixel, input frame_start);
endinterface

interface sem_res_if;
	import sem_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] magnitude;
	logic [POS_W-1:0] out_row;
	logic [POS_W-1:0] out_col;
	logic             frame_done;
	modport source (output valid, output magnitude, output out_row, output out_col,
		output frame_done, input ready);
	modport sink (input valid, input magnitude, input out_row, input out_col,
		input frame_done, output ready);
	modport monitor (input valid, input ready, input magnitude, input out_row,
		input out_col, input frame_done);
endinterface

interface sem_cfg_if;
	import sem_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
	modport monitor (input valid, input ready, input index, input data);
endinterface

// ----- rtl/sem_front.sv -----
// sem_front: pixel intake, position counters, size registers, two line stores
// and the 3x3 window; pushes interior windows into the queue. Depends on sem_pkg, sem_if.
module sem_front #(
	parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sem_pix_if.sink               pixels,
	sem_cfg_if.sink               cfg,
	input  sem_pkg::sem_qstat_t   qstat,
	output logic                  push,
	output sem_pkg::sem_item_t    push_item
);
	import sem_pkg::*;

	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int WCW = AW + 1;
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int RCW = RW + 1;

	logic [WCW-1:0] w_q;
	logic [RCW-1:0] h_q;
	logic [AW-1:0]  col_q;
	logic [RW-1:0]  row_q;

	logic [PIX_W-1:0] upper_mem  [0:MAX_WIDTH-1];
	logic [PIX_W-1:0] middle_mem [0:MAX_WIDTH-1];

	logic             vld_s1;
	logic [PIX_W-1:0] px_s1;
	logic [AW-1:0]    addr_s1;
	logic             fwd_s1;
	logic             int_s1;
	sem_meta_t        meta_s1;
	logic [PIX_W-1:0] rd_top_s1;
	logic [PIX_W-1:0] rd_mid_s1;
	logic [PIX_W-1:0] fwd_top_q;
	logic [PIX_W-1:0] fwd_mid_q;

	logic [WIN_N-1:0][PIX_W-1:0] win_q;
	logic [WIN_N-1:0][PIX_W-1:0] win_next;

	logic           accept;
	logic           complete;
	logic [AW-1:0]  c_use;
	logic [RW-1:0]  r_use;
	logic [WCW-1:0] c_inc;
	logic [RCW-1:0] r_inc;
	logic           wrap_c;
	logic           wrap_r;
	logic           interior;
	logic           last_px;
	logic [PIX_W-1:0] top_col;
	logic [PIX_W-1:0] mid_col;

	// config writes, always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WCW'(clamp_size(RESET_WIDTH, MAX_WIDTH));
			h_q <= RCW'(clamp_size(RESET_HEIGHT, MAX_HEIGHT));
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == REG_IMAGE_WIDTH) begin
				w_q <= WCW'(clamp_size(cfg.data, MAX_WIDTH));
			end
			if (cfg.index == REG_IMAGE_HEIGHT) begin
				h_q <= RCW'(clamp_size(cfg.data, MAX_HEIGHT));
			end
		end
	end

	// stage s1 retires when its window has somewhere to go
	assign complete     = vld_s1 && (!int_s1 || !qstat.full);
	assign pixels.ready = !vld_s1 || complete;
	assign accept       = pixels.valid && pixels.ready;

	// position of this pixel; frame start forces 0,0
	always_comb begin
		c_use    = pixels.frame_start ? '0 : col_q;
		r_use    = pixels.frame_start ? '0 : row_q;
		c_inc    = WCW'(c_use) + WCW'(1);
		r_inc    = RCW'(r_use) + RCW'(1);
		wrap_c   = (c_inc >= w_q);
		wrap_r   = (r_inc >= h_q);
		interior = (r_use >= RW'(2)) && (c_use >= AW'(2));
		last_px  = (WCW'(c_use) == w_q - WCW'(1)) && (RCW'(r_use) == h_q - RCW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (accept) begin
				col_q <= wrap_c ? '0 : c_inc[AW-1:0];
				row_q <= wrap_c ? (wrap_r ? '0 : r_inc[RW-1:0]) : r_use;
			end
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (complete) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1        <= pixels.pixel;
			addr_s1      <= c_use;
			int_s1       <= interior;
			// same column as the pixel retiring now: its write is not in the store yet
			fwd_s1       <= vld_s1 && (c_use == addr_s1);
			meta_s1.row  <= POS_W'(r_use - RW'(1));
			meta_s1.col  <= POS_W'(c_use - AW'(1));
			meta_s1.done <= last_px;
		end
		if (complete) begin
			fwd_top_q <= mid_col;
			fwd_mid_q <= px_s1;
		end
	end

	// line stores: read at intake, write back when s1 retires
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_top_s1 <= upper_mem[c_use];
			rd_mid_s1 <= middle_mem[c_use];
		end
		if (complete) begin
			upper_mem[addr_s1]  <= mid_col;
			middle_mem[addr_s1] <= px_s1;
		end
	end

	assign top_col = fwd_s1 ? fwd_top_q : rd_top_s1;
	assign mid_col = fwd_s1 ? fwd_mid_q : rd_mid_s1;

	always_comb begin
		win_next[0] = win_q[1];
		win_next[1] = win_q[2];
		win_next[2] = top_col;
		win_next[3] = win_q[4];
		win_next[4] = win_q[5];
		win_next[5] = mid_col;
		win_next[6] = win_q[7];
		win_next[7] = win_q[8];
		win_next[8] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (complete) begin
			win_q <= win_next;
		end
	end

	assign push           = complete && int_s1;
	assign push_item.win  = win_next;
	assign push_item.meta = meta_s1;

endmodule

// ----- rtl/sem_queue.sv -----
// sem_queue: short FIFO of windows between front and back.
// Depends on sem_pkg.
module sem_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sem_pkg::sem_item_t  push_item,
	input  logic                pop,
	output sem_pkg::sem_item_t  head,
	output sem_pkg::sem_qstat_t qstat
);
	import sem_pkg::*;

	localparam int QPW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCW = $clog2(Q_DEPTH + 1);

	sem_item_t      entry_q [0:Q_DEPTH-1];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic           do_push;
	logic           do_pop;

	assign qstat.full  = (count_q == QCW'(Q_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + QPW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + QPW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

endmodule

// ----- rtl/sem_back.sv -----
// sem_back: Sobel gradients, energy and a bit-pair-per-stage integer square root,
// one stalling pipeline ending in the result register. Depends on sem_pkg, sem_if.
module sem_back (
	input  logic                clk,
	input  logic                arst_n,
	input  sem_pkg::sem_item_t  head,
	input  sem_pkg::sem_qstat_t qstat,
	output logic                pop,
	sem_res_if.source           results
);
	import sem_pkg::*;

	localparam int SQ_N = 8;

	function automatic logic [9:0] wsum(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
	endfunction

	function automatic logic [9:0] absdiff(input logic [9:0] a, input logic [9:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	logic            en;
	logic            v_s1;
	logic [9:0]      ax_s1;
	logic [9:0]      ay_s1;
	sem_meta_t       meta_s1;
	logic            v_s2;
	logic [19:0]     ex_s2;
	logic [19:0]     ey_s2;
	sem_meta_t       meta_s2;
	logic [20:0]     esum;

	// square root pipeline, index 0 is the energy stage
	logic            sq_v_s    [0:SQ_N];
	logic [15:0]     sq_e_s    [0:SQ_N];
	logic            sq_sat_s  [0:SQ_N];
	logic [9:0]      sq_rem_s  [0:SQ_N];
	logic [7:0]      sq_root_s [0:SQ_N];
	sem_meta_t       sq_meta_s [0:SQ_N];

	logic [10:0]     cand  [0:SQ_N-1];
	logic [10:0]     trial [0:SQ_N-1];
	logic            take  [0:SQ_N-1];

	assign en  = !sq_v_s[SQ_N] || results.ready;
	assign pop = en && !qstat.empty;

	assign esum = {1'b0, ex_s2} + {1'b0, ey_s2};

	always_comb begin
		for (int k = 0; k < SQ_N; k++) begin
			cand[k]  = {sq_rem_s[k][8:0], sq_e_s[k][15-2*k -: 2]};
			trial[k] = {1'b0, sq_root_s[k], 2'b01};
			take[k]  = (cand[k] >= trial[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int k = 0; k <= SQ_N; k++) begin
				sq_v_s[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1      <= !qstat.empty;
			v_s2      <= v_s1;
			sq_v_s[0] <= v_s2;
			for (int k = 0; k < SQ_N; k++) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1   <= absdiff(wsum(head.win[2], head.win[5], head.win[8]),
				wsum(head.win[0], head.win[3], head.win[6]));
			ay_s1   <= absdiff(wsum(head.win[6], head.win[7], head.win[8]),
				wsum(head.win[0], head.win[1], head.win[2]));
			meta_s1 <= head.meta;

			ex_s2   <= {10'd0, ax_s1} * {10'd0, ax_s1};
			ey_s2   <= {10'd0, ay_s1} * {10'd0, ay_s1};
			meta_s2 <= meta_s1;

			sq_e_s[0]    <= esum[15:0];
			sq_sat_s[0]  <= (esum[20:16] != 5'd0);
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
			sq_meta_s[0] <= meta_s2;

			for (int k = 0; k < SQ_N; k++) begin
				sq_e_s[k+1]    <= sq_e_s[k];
				sq_sat_s[k+1]  <= sq_sat_s[k];
				sq_meta_s[k+1] <= sq_meta_s[k];
				sq_rem_s[k+1]  <= take[k] ? 10'(cand[k] - trial[k]) : cand[k][9:0];
				sq_root_s[k+1] <= {sq_root_s[k][6:0], take[k]};
			end
		end
	end

	assign results.valid      = sq_v_s[SQ_N];
	assign results.magnitude  = sq_sat_s[SQ_N] ? MAG_SAT : sq_root_s[SQ_N];
	assign results.out_row    = sq_meta_s[SQ_N].row;
	assign results.out_col    = sq_meta_s[SQ_N].col;
	assign results.frame_done = sq_meta_s[SQ_N].done;

endmodule

// ----- rtl/sobel_edge_magnitude.sv -----
// sobel_edge_magnitude: top level of the streaming 3x3 Sobel edge magnitude block.
// Depends on sem_pkg, sem_if, sem_front, sem_queue, sem_back.
//
//   channel   dir   payload                                     transfer when
//   pixels    in    pixel[7:0], frame_start                     valid && ready
//   results   out   magnitude[7:0], out_row[9:0], out_col[9:0], valid && ready
//                   frame_done
//   cfg       in    index[3:0], data[10:0]                      valid && ready (ready = 1)
//
// Throughput: one pixel per clock while the queue has room, set by the front's single
// line-store pass (read at intake, write as s1 retires, bypassed when two pixels hit one column).
// Path: a pixel that completes an interior window goes from front s1 through the queue,
// back s1, s2, the energy stage and root steps to the result; border pixels give no result.
// Reset: counters, window and size registers (640 x 480, clamped to the maxima)
// clear at once; line stores are not cleared.
// Stalls: the back pipeline holds on results.ready low, the two-entry queue then
// fills, and only then does pixels.ready drop.
module sobel_edge_magnitude #(
	parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
	input  logic      clk,
	input  logic      arst_n,
	sem_pix_if.sink   pixels,
	sem_res_if.source results,
	sem_cfg_if.sink   cfg
);
	import sem_pkg::*;

	// front -> queue
	logic       push;
	sem_item_t  push_item;
	// queue -> back
	logic       pop;
	sem_item_t  head;
	sem_qstat_t qstat;

	// intake, counters, line stores, window
	sem_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pixels),
		.cfg       (cfg),
		.qstat     (qstat),
		.push      (push),
		.push_item (push_item)
	);

	// decouples the window producer from the math pipeline
	sem_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	// gradients, energy, square root, result register
	sem_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.qstat   (qstat),
		.pop     (pop),
		.results (results)
	);

endmodule

// ----- rtl/sem_checker.sv -----
// sem_checker: port-level assertions on the result channel, bound to the top level.
// Depends on sem_pkg, sobel_edge_magnitude.
module sem_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      valid,
	input logic                      ready,
	input logic [sem_pkg::PIX_W-1:0] magnitude,
	input logic [sem_pkg::POS_W-1:0] out_row,
	input logic [sem_pkg::POS_W-1:0] out_col,
	input logic                      frame_done
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid
			&& $stable(magnitude) && $stable(out_row)
			&& $stable(out_col) && $stable(frame_done))
		else $error("result changed while stalled");

	// reset empties the result pipeline
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !valid)
		else $error("result valid during reset");

	// results only for interior pixels
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> out_row >= 10'd1 && out_row <= 10'd1022
			&& out_col >= 10'd1 && out_col <= 10'd1022)
		else $error("result position on the border");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.valid      (results.valid),
	.ready      (results.ready),
	.magnitude  (results.magnitude),
	.out_row    (results.out_row),
	.out_col    (results.out_col),
	.frame_done (results.frame_done)
);

// ----- tb/sobel_edge_magnitude_test.sv -----
// sobel_edge_magnitude_test: self-checking bench for the streaming Sobel edge block,
// with a scoreboard class that predicts every edge result from the accepted pixels.
// Depends on sem_pkg, sem_if and the sobel_edge_magnitude RTL.
`timescale 1ns / 100ps

module sobel_edge_magnitude_test;
	import sem_pkg::*;

	localparam int RESULT_LATENCY = 12;          // pixel transfer to result
	localparam int DRAIN_PAD      = 2 * RESULT_LATENCY;
	localparam int LIMIT_CYCLES   = 200000;
	localparam int IDLE_PCT       = 28;
	localparam int PHASES         = 10;
	localparam int WIDE_PHASE     = 5;           // the one frame with a wide line
	localparam int WIDE_LINE      = 64;
	localparam int STEADY_PHASE   = 3;           // no idling on either side

	// Predicts one edge result per interior pixel and checks results in order.
	class edge_scoreboard;
		typedef struct packed {
			logic [PIX_W-1:0] magnitude;
			logic [POS_W-1:0] row;
			logic [POS_W-1:0] col;
			logic             done;
		} edge_t;

		edge_t            expected_edges[$];
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		logic [PIX_W-1:0] upper_line[DEF_MAX_WIDTH];
		logic [PIX_W-1:0] middle_line[DEF_MAX_WIDTH];
		logic [PIX_W-1:0] win[WIN_N];
		int               row_pos;
		int               col_pos;
		int               errors;
		int               pixels_seen;
		int               edges_checked;

		function new();
			width_reg  = RESET_WIDTH;
			height_reg = RESET_HEIGHT;
			foreach (upper_line[i]) begin
				upper_line[i]  = '0;
				middle_line[i] = '0;
			end
			foreach (win[i]) begin
				win[i] = '0;
			end
			row_pos       = 0;
			col_pos       = 0;
			errors        = 0;
			pixels_seen   = 0;
			edges_checked = 0;
		endfunction

		function int span(logic [CFG_W-1:0] v, int hi);
			int s;
			s = int'(v);
			if (s < MIN_SIZE) s = MIN_SIZE;
			if (s > hi) s = hi;
			return s;
		endfunction

		function int active_width();
			return span(width_reg, DEF_MAX_WIDTH);
		endfunction

		function int pending();
			return expected_edges.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
			if (index == REG_IMAGE_WIDTH) begin
				width_reg = data;
			end else if (index == REG_IMAGE_HEIGHT) begin
				height_reg = data;
			end
		endfunction

		// floor square root, saturated once the energy reaches 256^2
		function logic [PIX_W-1:0] edge_root(int unsigned energy);
			int unsigned r;
			int unsigned t;
			int unsigned b;
			if (energy >= 65536) return MAG_SAT;
			r = 0;
			for (b = 128; b != 0; b = b >> 1) begin
				t = r | b;
				if (t * t <= energy) r = t;
			end
			return r[PIX_W-1:0];
		endfunction

		function void note_pixel(logic [PIX_W-1:0] px, logic fs);
			int          w;
			int          h;
			int          r;
			int          c;
			int          gx;
			int          gy;
			int unsigned energy;
			logic [31:0] pos;
			logic [PIX_W-1:0] up;
			logic [PIX_W-1:0] mid;
			edge_t       e;
			w = span(width_reg, DEF_MAX_WIDTH);
			h = span(height_reg, DEF_MAX_HEIGHT);
			pixels_seen++;
			if (fs) begin
				row_pos = 0;
				col_pos = 0;
			end
			r = row_pos;
			c = col_pos;
			if (c >= DEF_MAX_WIDTH) c = DEF_MAX_WIDTH - 1;
			up  = upper_line[c];
			mid = middle_line[c];
			upper_line[c]  = mid;
			middle_line[c] = px;
			for (int i = 0; i < 3; i++) begin
				win[3*i]   = win[3*i+1];
				win[3*i+1] = win[3*i+2];
			end
			win[2] = up;
			win[5] = mid;
			win[8] = px;
			if (r >= 2 && c >= 2) begin
				gx = (int'(win[2]) + 2 * int'(win[5]) + int'(win[8]))
				   - (int'(win[0]) + 2 * int'(win[3]) + int'(win[6]));
				gy = (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]))
				   - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
				energy = gx * gx + gy * gy;
				e.magnitude = edge_root(energy);
				pos   = r - 1;
				e.row = pos[POS_W-1:0];
				pos   = c - 1;
				e.col = pos[POS_W-1:0];
				e.done = (r == h - 1) && (c == w - 1);
				expected_edges.push_back(e);
			end
			c = c + 1;
			if (c >= w) begin
				c = 0;
				r = r + 1;
				if (r >= h) r = 0;
			end
			col_pos = c;
			row_pos = r;
		endfunction

		function void check_result(logic [PIX_W-1:0] magnitude, logic [POS_W-1:0] row,
				logic [POS_W-1:0] col, logic done);
			edge_t e;
			if (expected_edges.size() == 0) begin
				$error("unexpected edge result: row %0d col %0d magnitude %0d",
					row, col, magnitude);
				errors++;
				return;
			end
			e = expected_edges.pop_front();
			edges_checked++;
			if (magnitude !== e.magnitude) begin
				$error("magnitude: expected %0d, actual %0d", e.magnitude, magnitude);
				errors++;
			end
			if (row !== e.row) begin
				$error("out_row: expected %0d, actual %0d", e.row, row);
				errors++;
			end
			if (col !== e.col) begin
				$error("out_col: expected %0d, actual %0d", e.col, col);
				errors++;
			end
			if (done !== e.done) begin
				$error("frame_done: expected %0d, actual %0d", e.done, done);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   steady;          // set during the stretch with no idling on either side
	int   cycle_count;
	int   size_settings;

	edge_scoreboard sb;

	sem_pix_if pix_if ();
	sem_res_if res_if ();
	sem_cfg_if cfg_if ();

	sobel_edge_magnitude u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pix_if),
		.results (res_if),
		.cfg     (cfg_if)
	);

	always #10 clk = ~clk;

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("FAIL sobel_edge_magnitude");
			$finish;
		end
	end

	// Result side: ready is redrawn every falling edge; stalls land on any phase.
	always @(negedge clk) begin
		res_if.ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// A result transfer is sampled at the rising edge, before the block updates.
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			sb.check_result(res_if.magnitude, res_if.out_row, res_if.out_col,
				res_if.frame_done);
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer,
	// leaving valid high so back-to-back pixels stream without a bubble.
	task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			pix_if.valid       = 1'b0;
			pix_if.pixel       = PIX_W'($urandom_range(0, 255));
			pix_if.frame_start = 1'($urandom_range(0, 1));
			@(negedge clk);
		end
		pix_if.valid       = 1'b1;
		pix_if.pixel       = px;
		pix_if.frame_start = fs;
		do @(posedge clk); while (!pix_if.ready);
		sb.note_pixel(px, fs);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
		cfg_if.valid = 1'b1;
		cfg_if.index = index;
		cfg_if.data  = data;
		do @(posedge clk); while (!cfg_if.ready);
		sb.write_reg(index, data);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	// Wait for every expected edge, then give the pipeline time to finish
	// work on border pixels that produce nothing.
	task automatic settle();
		pix_if.valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_PAD) @(negedge clk);
	endtask

	// Hard edges are common so that saturation shows up often.
	function automatic logic [PIX_W-1:0] rand_pixel();
		if ($urandom_range(0, 3) == 0) begin
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		end
		return PIX_W'($urandom_range(0, 255));
	endfunction

	// One size setting: a run of random pixels with stray frame
	// marks. A frame mark is forced when the line grows, since columns past the
	// old width have not been written in the current frame yet. Without a mark
	// the counters may sit past the new size and wrap on their own.
	task automatic run_phase(input logic [CFG_W-1:0] w_data, input logic [CFG_W-1:0] h_data,
			input int count, input int noise_pct);
		int   old_w;
		logic mark;
		logic fs;
		settle();
		old_w = sb.active_width();
		write_reg(REG_IMAGE_WIDTH, w_data);
		write_reg(REG_IMAGE_HEIGHT, h_data);
		size_settings++;
		mark = (sb.active_width() > old_w) || ($urandom_range(0, 1) == 1);
		for (int i = 0; i < count; i++) begin
			fs = (i == 0) ? mark : ($urandom_range(0, 99) < noise_pct);
			send_pixel(rand_pixel(), fs);
		end
	endtask

	// Three-by-three frame, row by row.
	task automatic send_frame(input logic [PIX_W-1:0] px[9], input logic mark);
		for (int i = 0; i < 9; i++) begin
			send_pixel(px[i], (i == 0) ? mark : 1'b0);
		end
	endtask

	initial begin
		logic [PIX_W-1:0] frame_px[9];
		logic [CFG_W-1:0] w_data;
		logic [CFG_W-1:0] h_data;
		clk                = 1'b0;
		arst_n             = 1'b0;
		steady             = 1'b0;
		cycle_count        = 0;
		size_settings      = 0;
		pix_if.valid       = 1'b0;
		pix_if.pixel       = '0;
		pix_if.frame_start = 1'b0;
		res_if.ready       = 1'b0;
		cfg_if.valid       = 1'b0;
		cfg_if.index       = REG_IMAGE_WIDTH;
		cfg_if.data        = '0;
		sb = new();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed: sizes below the minimum clamp to 3x3, one interior pixel each.
		write_reg(REG_IMAGE_WIDTH, 11'd0);
		write_reg(REG_IMAGE_HEIGHT, 11'd2);
		size_settings++;
		// vertical step 0 -> 255: gx at its maximum, saturates
		frame_px = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255};
		send_frame(frame_px, 1'b1);
		// next frame follows with no mark; negative gx, energy 2 -> root 1
		frame_px = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0};
		send_frame(frame_px, 1'b0);
		// two stray pixels, then a mark restarts the frame mid row
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		// flat white: zero gradient
		frame_px = '{default: 8'd255};
		send_frame(frame_px, 1'b1);

		// Random part. One phase runs a wide line; the rest stay small.
		for (int p = 0; p < PHASES; p++) begin
			steady = (p == STEADY_PHASE);
			if (p == WIDE_PHASE) begin
				// two rows fill the stores before the first result
				run_phase(CFG_W'(WIDE_LINE), 11'd0, 2 * WIDE_LINE + 40, 0);
			end else begin
				w_data = ($urandom_range(0, 4) == 0) ? CFG_W'($urandom_range(0, 2))
					: CFG_W'($urandom_range(3, 12));
				if (p == 1) begin
					h_data = 11'd1024;
				end else if (p == 7) begin
					h_data = 11'h7FF;
				end else begin
					h_data = CFG_W'($urandom_range(0, 9));
				end
				run_phase(w_data, h_data, steady ? 100 : $urandom_range(24, 40), 2);
			end
		end
		steady = 1'b0;
		settle();

		$display("Run covered %0d pixel transfers under %0d frame size settings,",
			sb.pixels_seen, size_settings);
		$display("with %0d edge results compared field by field.", sb.edges_checked);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS sobel_edge_magnitude");
		end else begin
			$display("FAIL sobel_edge_magnitude");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/sem_pkg.sv
rtl/sem_if.sv
rtl/sem_front.sv
rtl/sem_queue.sv
rtl/sem_back.sv
rtl/sobel_edge_magnitude.sv
rtl/sem_checker.sv
tb/sobel_edge_magnitude_test.sv
